### rtl/core/atfc_pkg.sv
// ----------------------------------------------------------------------------
// atfc_pkg: shared types and constants for the averaged fan curve block
// Field widths, configuration register codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package atfc_pkg;

    localparam int SAMPLE_W   = 18;
    localparam int DUTY_W     = 7;
    localparam int AVG_W      = 5;
    localparam int TEMP_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Bits of quotient produced by the serial divider in each mode
    localparam int MEAN_DIV_STEPS = SAMPLE_W;
    localparam int DUTY_DIV_STEPS = DUTY_W;

    localparam logic [DUTY_W-1:0] DUTY_FULL   = 7'd100;
    localparam logic [AVG_W-1:0]  AVG_RESET   = 5'd4;
    localparam logic [TEMP_W-1:0] MIN_T_RESET = 8'd40;
    localparam logic [TEMP_W-1:0] MAX_T_RESET = 8'd70;
    localparam logic [DUTY_W-1:0] LEVEL_RESET = 7'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AVG_SAMPLES = 2'd0,
        REG_MIN_TEMP    = 2'd1,
        REG_MAX_TEMP    = 2'd2,
        REG_MIN_LEVEL   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [AVG_W-1:0]  avg_samples;
        logic [TEMP_W-1:0] min_temp;
        logic [TEMP_W-1:0] max_temp;
        logic [DUTY_W-1:0] min_level;
    } cfg_t;

    typedef struct packed {
        logic sample_load;  // capture the accepted sample, clear fill pointer
        logic fill_write;   // prime one ring slot with the sample
        logic slot_write;   // write the sample at the current write slot
        logic sum_start;    // clear the accumulator and read pointer
        logic sum_read;     // issue one ring read
        logic div_start;    // launch the serial divider
        logic div_duty;     // divider works on the duty ratio (else the mean)
        logic mean_load;    // take the quotient as the mean
        logic mul_lo;       // lower threshold times count
        logic mul_hi;       // upper threshold times count
        logic cmp;          // threshold compare, ramp span and offset
        logic mul_a;        // offset times remaining duty span
        logic mul_b;        // minimum level times ramp span
        logic duty_load;    // take the quotient as the duty
        logic out_load;     // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic sum_last;
        logic div_done;
        logic le_lo;
        logic ge_hi;
    } status_t;

    // Whole degrees to millidegrees: 1000 = 1024 - 16 - 8
    function automatic logic [SAMPLE_W-1:0] deg_to_milli(input logic [TEMP_W-1:0] deg);
        logic [SAMPLE_W-1:0] d;
        d = SAMPLE_W'(deg);
        return (d << 10) - (d << 4) - (d << 3);
    endfunction

endpackage

### rtl/core/atfc_ram.sv
// ----------------------------------------------------------------------------
// atfc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module atfc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/atfc_div.sv
// ----------------------------------------------------------------------------
// atfc_div: restoring serial divider, one quotient bit per cycle
// The quotient is known to fit in 18 bits (mean) or 7 bits (duty), so the
// upper dividend bits seed the remainder and only that many steps are run.
// ----------------------------------------------------------------------------
module atfc_div #(
    parameter int DVD_W = 31,
    parameter int DVS_W = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          duty_mode,
    input  logic [DVD_W-1:0]              dividend,
    input  logic [DVS_W-1:0]              divisor,
    output logic [atfc_pkg::SAMPLE_W-1:0] quotient,
    output logic                          done
);

    localparam int QW    = atfc_pkg::SAMPLE_W;
    localparam int STEPW = $clog2(QW + 1);

    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [QW-1:0]    q_reg;
    logic [STEPW-1:0] step_reg;
    logic             done_reg;

    logic [DVS_W+1:0] trial;
    logic [DVS_W-1:0] rem_init;
    logic [QW-1:0]    q_init;

    always_comb begin
        if (duty_mode) begin
            rem_init = DVS_W'(dividend >> atfc_pkg::DUTY_DIV_STEPS);
            q_init   = QW'(dividend[atfc_pkg::DUTY_DIV_STEPS-1:0])
                       << (QW - atfc_pkg::DUTY_DIV_STEPS);
        end else begin
            rem_init = DVS_W'(dividend >> atfc_pkg::MEAN_DIV_STEPS);
            q_init   = dividend[QW-1:0];
        end
    end

    assign trial = {1'b0, rem_reg, q_reg[QW-1]} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                step_reg <= duty_mode ? STEPW'(atfc_pkg::DUTY_DIV_STEPS)
                                      : STEPW'(atfc_pkg::MEAN_DIV_STEPS);
            end else if (step_reg != '0) begin
                step_reg <= step_reg - 1'b1;
                done_reg <= (step_reg == STEPW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            q_reg   <= q_init;
            dvs_reg <= divisor;
        end else if (step_reg != '0) begin
            if (!trial[DVS_W+1]) begin
                rem_reg <= trial[DVS_W-1:0];
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[DVS_W-2:0], q_reg[QW-1]};
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

### rtl/core/atfc_dp.sv
// ----------------------------------------------------------------------------
// atfc_dp: datapath of the averaged fan curve
// Sample ring, running sum, shared multiplier, threshold compare, serial
// divider and result registers, all stepped by the controller's commands.
// ----------------------------------------------------------------------------
module atfc_dp #(
    parameter int RING_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  atfc_pkg::cfg_t                cfg,
    input  atfc_pkg::cmd_t                cmd,
    output atfc_pkg::status_t             status,
    input  logic [atfc_pkg::SAMPLE_W-1:0] sample_in,
    output logic [atfc_pkg::SAMPLE_W-1:0] mean_out,
    output logic [atfc_pkg::DUTY_W-1:0]   duty_out
);

    localparam int SW      = atfc_pkg::SAMPLE_W;
    localparam int DW      = atfc_pkg::DUTY_W;
    localparam int ADDR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int SUM_W   = SW + ADDR_W;
    localparam int MUL_A_W = SW + CNT_W;
    localparam int MUL_B_W = (CNT_W > DW) ? CNT_W : DW;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int TERM_W  = MUL_A_W + DW;
    localparam int DVD_W   = TERM_W + 1;
    localparam int DVS_W   = MUL_A_W + 1;

    logic [SW-1:0]      sample_reg;
    logic [ADDR_W-1:0]  write_slot_reg;
    logic [ADDR_W-1:0]  write_slot_next;
    logic [ADDR_W-1:0]  fill_idx_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic               acc_en_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SW-1:0]      mean_reg;
    logic [MUL_A_W-1:0] lo_reg;
    logic [MUL_A_W-1:0] hi_reg;
    logic [MUL_A_W-1:0] den_reg;
    logic [MUL_A_W-1:0] diff_reg;
    logic [TERM_W-1:0]  term_a_reg;
    logic [TERM_W-1:0]  term_b_reg;
    logic [DW-1:0]      duty_reg;
    logic [SW-1:0]      mean_out_reg;
    logic [DW-1:0]      duty_out_reg;

    logic [CNT_W-1:0]   n_eff;
    logic [DW-1:0]      level;
    logic [CNT_W-1:0]   slot_cur;
    logic [CNT_W-1:0]   slot_inc;
    logic [CNT_W-1:0]   slot_ext;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [SW-1:0]      ram_rdata;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  product;
    logic [MUL_A_W-1:0] sum_ext;
    logic [TERM_W-1:0]  num;
    logic [DVD_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
    logic [SW-1:0]      quotient;
    logic               div_done;

    // Averaging count: zero counts as one, saturates at the ring depth
    always_comb begin
        priority if (cfg.avg_samples == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(cfg.avg_samples) > RING_DEPTH) begin
            n_eff = CNT_W'(RING_DEPTH);
        end else begin
            n_eff = CNT_W'(cfg.avg_samples);
        end
    end

    assign level = (cfg.min_level > atfc_pkg::DUTY_FULL) ? atfc_pkg::DUTY_FULL
                                                         : cfg.min_level;

    // A write slot left beyond a lowered count restarts at slot 0
    assign slot_ext        = CNT_W'(write_slot_reg);
    assign slot_cur        = (slot_ext >= n_eff) ? '0 : slot_ext;
    assign slot_inc        = slot_cur + 1'b1;
    assign write_slot_next = (slot_inc >= n_eff) ? '0 : ADDR_W'(slot_inc);

    assign ram_we    = cmd.fill_write | cmd.slot_write;
    assign ram_waddr = cmd.fill_write ? fill_idx_reg : slot_cur[ADDR_W-1:0];

    atfc_ram #(
        .WIDTH (SW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (sample_reg),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    // Shared multiplier
    always_comb begin
        priority if (cmd.mul_lo) begin
            mul_a = MUL_A_W'(atfc_pkg::deg_to_milli(cfg.min_temp));
            mul_b = MUL_B_W'(n_eff);
        end else if (cmd.mul_hi) begin
            mul_a = MUL_A_W'(atfc_pkg::deg_to_milli(cfg.max_temp));
            mul_b = MUL_B_W'(n_eff);
        end else if (cmd.mul_a) begin
            mul_a = diff_reg;
            mul_b = MUL_B_W'(atfc_pkg::DUTY_FULL - level);
        end else begin
            mul_a = den_reg;
            mul_b = MUL_B_W'(level);
        end
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign sum_ext = MUL_A_W'(sum_reg);
    assign num     = term_a_reg + term_b_reg;

    always_comb begin
        if (cmd.div_duty) begin
            dividend = {num, 1'b0} + DVD_W'(den_reg);
            divisor  = {den_reg, 1'b0};
        end else begin
            dividend = DVD_W'(sum_reg);
            divisor  = DVS_W'(n_eff);
        end
    end

    atfc_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .duty_mode (cmd.div_duty),
        .dividend  (dividend),
        .divisor   (divisor),
        .quotient  (quotient),
        .done      (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg <= '0;
            acc_en_reg     <= 1'b0;
        end else begin
            acc_en_reg <= cmd.sum_read;
            if (cmd.slot_write) begin
                write_slot_reg <= write_slot_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sample_load) begin
            sample_reg   <= sample_in;
            fill_idx_reg <= '0;
        end else if (cmd.fill_write) begin
            fill_idx_reg <= fill_idx_reg + 1'b1;
        end

        if (cmd.sum_start) begin
            rd_idx_reg <= '0;
            sum_reg    <= '0;
        end else begin
            if (cmd.sum_read) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (acc_en_reg) begin
                sum_reg <= sum_reg + SUM_W'(ram_rdata);
            end
        end

        if (cmd.mean_load) begin
            mean_reg <= quotient;
        end
        if (cmd.mul_lo) begin
            lo_reg <= MUL_A_W'(product);
        end
        if (cmd.mul_hi) begin
            hi_reg <= MUL_A_W'(product);
        end
        if (cmd.cmp) begin
            den_reg  <= hi_reg - lo_reg;
            diff_reg <= sum_ext - lo_reg;
            duty_reg <= status.le_lo ? level : atfc_pkg::DUTY_FULL;
        end
        if (cmd.mul_a) begin
            term_a_reg <= TERM_W'(product);
        end
        if (cmd.mul_b) begin
            term_b_reg <= TERM_W'(product);
        end
        if (cmd.duty_load) begin
            duty_reg <= quotient[DW-1:0];
        end
        if (cmd.out_load) begin
            mean_out_reg <= mean_reg;
            duty_out_reg <= duty_reg;
        end
    end

    assign status.fill_last = (fill_idx_reg == ADDR_W'(RING_DEPTH - 1));
    assign status.sum_last  = (rd_idx_reg == n_eff - 1'b1);
    assign status.div_done  = div_done;
    assign status.le_lo     = (sum_ext <= lo_reg);
    assign status.ge_hi     = (sum_ext >= hi_reg);

    assign mean_out = mean_out_reg;
    assign duty_out = duty_out_reg;

endmodule

### rtl/core/atfc_ctrl.sv
// ----------------------------------------------------------------------------
// atfc_ctrl: sequencing state machine of the averaged fan curve
// Primes the ring on the first sample, then steps write, sum, mean division,
// threshold compare, duty division if the mean is on the ramp, then output.
// ----------------------------------------------------------------------------
module atfc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  atfc_pkg::status_t status,
    output atfc_pkg::cmd_t    cmd
);

    typedef enum logic [14:0] {
        ST_IDLE  = 15'h0001,
        ST_FILL  = 15'h0002,
        ST_WRITE = 15'h0004,
        ST_SUM   = 15'h0008,
        ST_DRAIN = 15'h0010,
        ST_MDIV  = 15'h0020,
        ST_MWAIT = 15'h0040,
        ST_MULLO = 15'h0080,
        ST_MULHI = 15'h0100,
        ST_CMP   = 15'h0200,
        ST_MULA  = 15'h0400,
        ST_MULB  = 15'h0800,
        ST_DDIV  = 15'h1000,
        ST_DWAIT = 15'h2000,
        ST_OUT   = 15'h4000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   primed_reg;
    logic   primed_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        state_next   = state_reg;
        primed_next  = primed_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.sample_load = 1'b1;
                    state_next      = primed_reg ? ST_WRITE : ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill_write = 1'b1;
                if (status.fill_last) begin
                    primed_next = 1'b1;
                    state_next  = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.slot_write = 1'b1;
                cmd.sum_start  = 1'b1;
                state_next     = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_read = 1'b1;
                if (status.sum_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read data lands in the accumulator here
                state_next = ST_MDIV;
            end
            ST_MDIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (status.div_done) begin
                    cmd.mean_load = 1'b1;
                    state_next    = ST_MULLO;
                end
            end
            ST_MULLO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MULHI;
            end
            ST_MULHI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = (status.le_lo || status.ge_hi) ? ST_OUT : ST_MULA;
            end
            ST_MULA: begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MULB;
            end
            ST_MULB: begin
                cmd.mul_b  = 1'b1;
                state_next = ST_DDIV;
            end
            ST_DDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_duty  = 1'b1;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT: begin
                cmd.div_duty = 1'b1;
                if (status.div_done) begin
                    cmd.duty_load = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            primed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            primed_reg  <= primed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### rtl/core/averaged_temperature_fan_curve.sv
// ----------------------------------------------------------------------------
// averaged_temperature_fan_curve: moving-average temperature to fan duty
// Each sample (millidegrees) enters a ring; the mean of the last n samples
// and a linear fan curve duty (percent) come out as one result.
//
// Usage:
//   s_ channel: one sample per transaction (valid/ready).
//   m_ channel: mean and duty per transaction; one result per sample.
//   cfg_ channel: register index and data; always ready, write while idle.
// Sequence: the ring is read out one slot per cycle over n slots (n the
//   effective averaging count), the serial divider forms the mean (18
//   quotient bits) and, only when the mean lies on the ramp, the duty (7
//   quotient bits). The first sample after reset primes every ring slot.
// Flow: a new sample is taken only after the previous result has moved
//   into the output register; that register holds a finished result
//   while the next sample is already taken.
// Reset: configuration returns to defaults, the ring counts as unprimed.
// Stall: with m_ready low, a completed result waits in the sequencer until
//   the output register frees up; s_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module averaged_temperature_fan_curve #(
    parameter int RING_DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [atfc_pkg::SAMPLE_W-1:0]   s_sample_milli,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [atfc_pkg::SAMPLE_W-1:0]   m_mean_milli,
    output logic [atfc_pkg::DUTY_W-1:0]     m_fan_duty,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [atfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [atfc_pkg::CFG_DATA_W-1:0] cfg_data
);

    atfc_pkg::cfg_t    cfg_reg;
    atfc_pkg::cmd_t    cmd;
    atfc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.avg_samples <= atfc_pkg::AVG_RESET;
            cfg_reg.min_temp    <= atfc_pkg::MIN_T_RESET;
            cfg_reg.max_temp    <= atfc_pkg::MAX_T_RESET;
            cfg_reg.min_level   <= atfc_pkg::LEVEL_RESET;
        end else if (cfg_valid) begin
            unique case (atfc_pkg::cfg_reg_t'(cfg_index))
                atfc_pkg::REG_AVG_SAMPLES:
                    cfg_reg.avg_samples <= cfg_data[atfc_pkg::AVG_W-1:0];
                atfc_pkg::REG_MIN_TEMP:
                    cfg_reg.min_temp    <= cfg_data[atfc_pkg::TEMP_W-1:0];
                atfc_pkg::REG_MAX_TEMP:
                    cfg_reg.max_temp    <= cfg_data[atfc_pkg::TEMP_W-1:0];
                atfc_pkg::REG_MIN_LEVEL:
                    cfg_reg.min_level   <= cfg_data[atfc_pkg::DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    atfc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    atfc_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .status    (status),
        .sample_in (s_sample_milli),
        .mean_out  (m_mean_milli),
        .duty_out  (m_fan_duty)
    );

    // One sample in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second sample accepted while one is in flight");

    // The output register is never overwritten while it holds an untaken result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && m_valid) |-> m_ready)
        else $error("pending result overwritten");

    // Duty stays within percent range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fan_duty <= atfc_pkg::DUTY_FULL))
        else $error("fan duty above full scale");

    // Divider completion only comes while the sequencer waits on it
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> !s_ready)
        else $error("divider finished while idle");

endmodule
